// ===== rtl/grc_pkg.sv =====
// Shared types and constants of the grid raycaster column engine.
// Used by the controller, the datapath and the divider; depends on nothing.
`default_nettype none

package grc_pkg;

    localparam int RD_W = 28;   // signed ray component
    localparam int AX_W = 27;   // ray magnitude
    localparam int SD_W = 20;   // side distance numerator
    localparam int PW   = 48;   // cross products

    localparam int DIV_NW = 47;
    localparam int DIV_DW = 27;
    localparam int DIV_CW = 6;

    localparam int DIV_N_RAY  = 27;
    localparam int DIV_N_PERP = 34;
    localparam int DIV_N_HGT  = 38;
    localparam int DIV_N_HIT  = 47;

    localparam logic [2:0] DSEL_RX = 3'd0;
    localparam logic [2:0] DSEL_RY = 3'd1;
    localparam logic [2:0] DSEL_PD = 3'd2;
    localparam logic [2:0] DSEL_HT = 3'd3;
    localparam logic [2:0] DSEL_HC = 3'd4;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_SCR_W   = 3'd6;
    localparam logic [2:0] CFG_SCR_H   = 3'd7;

    localparam logic [16:0] PERP_MAX = 17'h1FFFF;
    localparam logic [11:0] HGT_MAX  = 12'hFFF;

    typedef struct packed {
        logic       clr;
        logic       wr;
        logic       cast;
        logic       ray_mul;
        logic       div_go;
        logic       div_take;
        logic [2:0] div_sel;
        logic       walk_init;
        logic       step;
        logic       fin_mul;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic stop;
        logic flat;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/grc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Numerator is left aligned so the quotient lands in the low bits; uses grc_pkg.
`default_nettype none

module grc_div
    import grc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    input  wire logic [DIV_CW-1:0] i_cnt,
    output logic                   o_done,
    output logic [DIV_NW-1:0]      o_quo,
    output logic [DIV_DW-1:0]      o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [DIV_NW-1:0] r_q, n_q;
    logic [DIV_DW-1:0] r_r, n_r;
    logic [DIV_DW:0]   w_t;
    logic [DIV_DW-1:0] r_den;

    assign w_t = {r_r, r_q[DIV_NW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_cnt;
            n_q    = i_num;
            n_r    = '0;
        end else if (r_busy) begin
            if (w_t >= {1'b0, r_den}) begin
                n_r = DIV_DW'(w_t - {1'b0, r_den});
                n_q = {r_q[DIV_NW-2:0], 1'b1};
            end else begin
                n_r = w_t[DIV_DW-1:0];
                n_q = {r_q[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - DIV_CW'(1);
            if (r_cnt == DIV_CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

endmodule

`default_nettype wire

// ===== rtl/grc_ctrl.sv =====
// Sequencer of the raycaster: map clear, map writes, ray setup, grid walk, divisions, result.
// Drives the datapath by grc_pkg command and status structs.
`default_nettype none

module grc_ctrl
    import grc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_opcode,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RMUL  = 5'd2;
    localparam logic [4:0] S_RX_GO = 5'd3;
    localparam logic [4:0] S_RX_WT = 5'd4;
    localparam logic [4:0] S_RY_GO = 5'd5;
    localparam logic [4:0] S_RY_WT = 5'd6;
    localparam logic [4:0] S_INIT  = 5'd7;
    localparam logic [4:0] S_STEP  = 5'd8;
    localparam logic [4:0] S_CHK   = 5'd9;
    localparam logic [4:0] S_FMUL  = 5'd10;
    localparam logic [4:0] S_PD_GO = 5'd11;
    localparam logic [4:0] S_PD_WT = 5'd12;
    localparam logic [4:0] S_HT_GO = 5'd13;
    localparam logic [4:0] S_HT_WT = 5'd14;
    localparam logic [4:0] S_HC_GO = 5'd15;
    localparam logic [4:0] S_HC_WT = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0] r_state, n_state;
    logic       r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov;
        o_cmd   = '0;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode) begin
                        o_cmd.cast = 1'b1;
                        n_state    = S_RMUL;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_RMUL: begin
                o_cmd.ray_mul = 1'b1;
                n_state       = S_RX_GO;
            end
            S_RX_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DSEL_RX;
                n_state       = S_RX_WT;
            end
            S_RX_WT: begin
                o_cmd.div_sel = DSEL_RX;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_RY_GO;
                end
            end
            S_RY_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DSEL_RY;
                n_state       = S_RY_WT;
            end
            S_RY_WT: begin
                o_cmd.div_sel = DSEL_RY;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state         = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                n_state = i_sts.stop ? S_FMUL : S_STEP;
            end
            S_FMUL: begin
                o_cmd.fin_mul = 1'b1;
                n_state       = i_sts.flat ? S_OUT : S_PD_GO;
            end
            S_PD_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DSEL_PD;
                n_state       = S_PD_WT;
            end
            S_PD_WT: begin
                o_cmd.div_sel = DSEL_PD;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_HT_GO;
                end
            end
            S_HT_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DSEL_HT;
                n_state       = S_HT_WT;
            end
            S_HT_WT: begin
                o_cmd.div_sel = DSEL_HT;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_HC_GO;
                end
            end
            S_HC_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DSEL_HC;
                n_state       = S_HC_WT;
            end
            S_HC_WT: begin
                o_cmd.div_sel = DSEL_HC;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ov           = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

endmodule

`default_nettype wire

// ===== rtl/grc_dp.sv =====
// Datapath of the raycaster: config registers, wall map memory, ray and DDA registers,
// shared divider and result registers. Uses grc_pkg and grc_div.
`default_nettype none

module grc_dp
    import grc_pkg::*;
#(
    parameter int MAP_DIM   = 64,
    parameter int MAX_STEPS = 100,
    parameter int TEX_SIZE  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [5:0]  i_cell_col,
    input  wire logic [5:0]  i_cell_row,
    input  wire logic [3:0]  i_cell_value,
    input  wire logic [9:0]  i_column,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    output logic [9:0]       o_out_column,
    output logic             o_hit,
    output logic             o_side,
    output logic [5:0]       o_hit_col,
    output logic [5:0]       o_hit_row,
    output logic [3:0]       o_wall_type,
    output logic [16:0]      o_perp_dist,
    output logic [11:0]      o_slice_height,
    output logic signed [11:0] o_slice_bottom,
    output logic [11:0]      o_slice_top,
    output logic [5:0]       o_tex_col
);

    localparam int AW    = $clog2(MAP_DIM);
    localparam int GW    = ((AW > 6) ? AW : 6) + 2;
    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int MW    = $clog2(DEPTH);
    localparam int DDW   = GW + 11;

    // configuration
    logic [15:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0]        r_scr_w, r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= 16'sd16384;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= 16'sd10638;
            r_scr_w   <= 11'd640;
            r_scr_h   <= 11'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data;
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data;
                CFG_PLANE_X: r_plane_x <= i_cfg_data;
                CFG_PLANE_Y: r_plane_y <= i_cfg_data;
                CFG_SCR_W:   r_scr_w   <= i_cfg_data[10:0];
                CFG_SCR_H:   r_scr_h   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // ray setup
    logic [9:0]            r_col;
    logic [10:0]           w_weff;
    logic signed [11:0]    w_k;
    logic signed [RD_W-1:0] r_prx, r_pry, r_rdx, r_rdy;

    assign w_weff = (r_scr_w == '0) ? 11'd1 : r_scr_w;
    assign w_k    = $signed({1'b0, r_col, 1'b0}) - $signed({1'b0, w_weff});

    always_ff @(posedge i_clk) begin
        if (i_cmd.cast) begin
            r_col <= i_column;
        end
        if (i_cmd.ray_mul) begin
            r_prx <= RD_W'(r_plane_x) * RD_W'(w_k);
            r_pry <= RD_W'(r_plane_y) * RD_W'(w_k);
        end
    end

    // walk registers
    logic [AX_W-1:0]      r_ax, r_ay, w_ax, w_ay;
    logic [SD_W-1:0]      r_nx, r_ny, r_pnum;
    logic [PW-1:0]        r_pxa, r_pya;
    logic signed [GW-1:0] r_gx, r_gy, w_ngx, w_ngy, w_gsel;
    logic                 r_side, r_far, r_out;
    logic [10:0]          w_nx0, w_ny0;
    logic                 w_take_x, w_in, w_far;
    logic [15:0]          w_psel;
    logic signed [DDW-1:0] w_diff;
    logic [DDW-1:0]       w_dabs;

    assign w_ax  = r_rdx[RD_W-1] ? AX_W'(-r_rdx) : AX_W'(r_rdx);
    assign w_ay  = r_rdy[RD_W-1] ? AX_W'(-r_rdy) : AX_W'(r_rdy);
    assign w_nx0 = r_rdx[RD_W-1] ? {1'b0, r_pos_x[9:0]} : 11'd1024 - {1'b0, r_pos_x[9:0]};
    assign w_ny0 = r_rdy[RD_W-1] ? {1'b0, r_pos_y[9:0]} : 11'd1024 - {1'b0, r_pos_y[9:0]};

    assign w_take_x = (r_ax != '0) && ((r_ay == '0) || (r_pxa < r_pya));

    always_comb begin
        w_ngx = r_gx;
        w_ngy = r_gy;
        if (w_take_x) begin
            w_ngx = r_rdx[RD_W-1] ? r_gx - GW'(1) : r_gx + GW'(1);
        end else begin
            w_ngy = r_rdy[RD_W-1] ? r_gy - GW'(1) : r_gy + GW'(1);
        end
    end

    assign w_gsel = w_take_x ? w_ngx : w_ngy;
    assign w_psel = w_take_x ? r_pos_x : r_pos_y;
    assign w_diff = DDW'($signed({w_gsel, 10'b0})) - DDW'($signed({1'b0, w_psel}));
    assign w_dabs = w_diff[DDW-1] ? DDW'(-w_diff) : DDW'(w_diff);
    assign w_far  = w_dabs[DDW-1:10] >= (DDW-10)'(MAX_STEPS);
    assign w_in   = !w_ngx[GW-1] && (w_ngx < GW'(MAP_DIM))
                 && !w_ngy[GW-1] && (w_ngy < GW'(MAP_DIM));

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_ax   <= w_ax;
            r_ay   <= w_ay;
            r_nx   <= SD_W'(w_nx0);
            r_ny   <= SD_W'(w_ny0);
            r_pxa  <= PW'(w_nx0) * PW'(w_ay);
            r_pya  <= PW'(w_ny0) * PW'(w_ax);
            r_gx   <= GW'(r_pos_x[15:10]);
            r_gy   <= GW'(r_pos_y[15:10]);
            r_side <= 1'b1;
            r_pnum <= '0;
        end else if (i_cmd.step) begin
            r_gx  <= w_ngx;
            r_gy  <= w_ngy;
            r_far <= w_far;
            r_out <= !w_in;
            if (w_take_x) begin
                r_pnum <= r_nx;
                r_nx   <= r_nx + SD_W'(1024);
                r_pxa  <= r_pxa + PW'({r_ay, 10'b0});
                r_side <= 1'b0;
            end else begin
                r_pnum <= r_ny;
                r_ny   <= r_ny + SD_W'(1024);
                r_pya  <= r_pya + PW'({r_ax, 10'b0});
                r_side <= 1'b1;
            end
        end
    end

    // wall map
    logic [3:0]    r_map [DEPTH];
    logic [3:0]    r_rd;
    logic [MW-1:0] r_clr_addr, w_waddr, w_raddr;
    logic [3:0]    w_wdata;
    logic          w_cell_ok, w_we;

    assign w_cell_ok = (9'(i_cell_col) < 9'(MAP_DIM)) && (9'(i_cell_row) < 9'(MAP_DIM));
    assign w_we      = i_cmd.clr || (i_cmd.wr && w_cell_ok);
    assign w_waddr   = i_cmd.clr ? r_clr_addr
                     : MW'(MW'(i_cell_row) * MW'(MAP_DIM) + MW'(i_cell_col));
    assign w_wdata   = i_cmd.clr ? 4'd0 : i_cell_value;
    assign w_raddr   = w_in ? MW'(MW'(w_ngy[AW-1:0]) * MW'(MAP_DIM) + MW'(w_ngx[AW-1:0]))
                            : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + MW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wdata;
        end
        if (i_cmd.step) begin
            r_rd <= r_map[w_raddr];
        end
    end

    // finishing products
    logic [AX_W-1:0]        w_den;
    logic signed [RD_W-1:0] w_oth;
    logic [15:0]            w_base;
    logic [37:0]            r_hden;
    logic signed [PW-1:0]   r_opn;

    assign w_den  = r_side ? r_ay : r_ax;
    assign w_oth  = r_side ? r_rdx : r_rdy;
    assign w_base = r_side ? r_pos_x : r_pos_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_mul) begin
            r_hden <= 38'(r_scr_h) * 38'(w_den);
            r_opn  <= PW'(w_oth) * PW'($signed({1'b0, r_pnum}));
        end
    end

    // shared divider
    logic [DIV_NW-1:0] w_dnum, w_quo, w_fl;
    logic [DIV_DW-1:0] w_dden, w_rem;
    logic [DIV_CW-1:0] w_dcnt;
    logic              w_neg, w_ddone;
    logic [AX_W-1:0]   w_aprx, w_apry;
    logic [46:0]       w_aopn;

    assign w_aprx = r_prx[RD_W-1] ? AX_W'(-r_prx) : AX_W'(r_prx);
    assign w_apry = r_pry[RD_W-1] ? AX_W'(-r_pry) : AX_W'(r_pry);
    assign w_aopn = r_opn[PW-1] ? 47'(-r_opn) : 47'(r_opn);

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_RX: begin
                w_dnum = DIV_NW'(w_aprx) << (DIV_NW - DIV_N_RAY);
                w_dden = DIV_DW'(w_weff);
                w_dcnt = DIV_CW'(DIV_N_RAY);
                w_neg  = r_prx[RD_W-1];
            end
            DSEL_PD: begin
                w_dnum = DIV_NW'({r_pnum, 14'b0}) << (DIV_NW - DIV_N_PERP);
                w_dden = DIV_DW'(w_den);
                w_dcnt = DIV_CW'(DIV_N_PERP);
                w_neg  = 1'b0;
            end
            DSEL_HT: begin
                w_dnum = DIV_NW'(r_hden) << (DIV_NW - DIV_N_HGT);
                w_dden = DIV_DW'({r_pnum, 4'b0});
                w_dcnt = DIV_CW'(DIV_N_HGT);
                w_neg  = 1'b0;
            end
            DSEL_HC: begin
                w_dnum = DIV_NW'(w_aopn) << (DIV_NW - DIV_N_HIT);
                w_dden = DIV_DW'(w_den);
                w_dcnt = DIV_CW'(DIV_N_HIT);
                w_neg  = r_opn[PW-1];
            end
            default: begin
                w_dnum = DIV_NW'(w_apry) << (DIV_NW - DIV_N_RAY);
                w_dden = DIV_DW'(w_weff);
                w_dcnt = DIV_CW'(DIV_N_RAY);
                w_neg  = r_pry[RD_W-1];
            end
        endcase
    end

    grc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .i_cnt   (w_dcnt),
        .o_done  (w_ddone),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // floor of a signed quotient: q when non-negative, else -q, or -q-1 with a remainder
    assign w_fl = !w_neg ? w_quo : ((w_rem != '0) ? ~w_quo : DIV_NW'(-w_quo));

    logic [16:0] r_perp;
    logic [11:0] r_hgt;
    logic [9:0]  r_hfr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_take) begin
            case (i_cmd.div_sel)
                DSEL_RX: r_rdx <= RD_W'(r_dir_x) + w_fl[RD_W-1:0];
                DSEL_RY: r_rdy <= RD_W'(r_dir_y) + w_fl[RD_W-1:0];
                DSEL_PD: r_perp <= (w_quo[DIV_NW-1:17] != '0) ? PERP_MAX : w_quo[16:0];
                DSEL_HT: r_hgt <= (w_quo[DIV_NW-1:12] != '0) ? HGT_MAX : w_quo[11:0];
                DSEL_HC: r_hfr <= w_fl[9:0];
                default: ;
            endcase
        end
    end

    // result
    logic        w_dz, w_pz, w_mir;
    logic [16:0] w_perp;
    logic [11:0] w_hgt;
    logic [9:0]  w_frac, w_half;
    logic [18:0] w_tprod;
    logic [7:0]  w_tx, w_txm;
    logic [10:0] w_hh;

    assign w_dz    = (w_den == '0);
    assign w_pz    = (r_pnum == '0);
    assign w_perp  = w_dz ? PERP_MAX : (w_pz ? 17'd0 : r_perp);
    assign w_hgt   = w_dz ? 12'd0 : (w_pz ? HGT_MAX : r_hgt);
    assign w_frac  = (w_dz || w_pz) ? w_base[9:0] : w_base[9:0] + r_hfr;
    assign w_tprod = 19'(w_frac) * 19'(TEX_SIZE);
    assign w_tx    = w_tprod[17:10];
    assign w_mir   = (!r_side && !r_rdx[RD_W-1] && (r_rdx != '0)) || (r_side && r_rdy[RD_W-1]);
    assign w_txm   = w_mir ? 8'(TEX_SIZE - 1) - w_tx : w_tx;
    assign w_half  = r_scr_h[10:1];
    assign w_hh    = 11'(w_hgt[11:1]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_column   <= r_col;
            o_hit          <= r_out || (r_rd != '0);
            o_side         <= r_side;
            o_hit_col      <= r_gx[5:0];
            o_hit_row      <= r_gy[5:0];
            o_wall_type    <= r_out ? 4'd0 : r_rd;
            o_perp_dist    <= w_perp;
            o_slice_height <= w_hgt;
            o_slice_bottom <= $signed({2'b0, w_half} - {1'b0, w_hh});
            o_slice_top    <= {2'b0, w_half} + {1'b0, w_hh};
            o_tex_col      <= w_txm[5:0];
        end
    end

    assign o_sts.clr_last = (r_clr_addr == MW'(DEPTH - 1));
    assign o_sts.div_done = w_ddone;
    assign o_sts.stop     = r_out || (r_rd != '0) || r_far;
    assign o_sts.flat     = w_dz || w_pz;

endmodule

`default_nettype wire

// ===== rtl/grid_raycast_column.sv =====
// Top level of the grid raycaster column engine.
// Instantiates grc_ctrl and grc_dp; uses grc_pkg.
//
// After reset the wall map is cleared one cell per cycle, all MAP_DIM*MAP_DIM cells (4096 at the
// default size), during which no beat is taken on the input. A map write gives no result. A cast
// uses the shared bit-serial divider (two ray divisions of 27 quotient bits, then perpendicular
// distance, slice height and hit point of 34, 38 and 47 bits, each with a start state and a
// wait state that hands the result over) and the grid walk, which does one map memory read per
// cell. The three finishing divisions are skipped when the distance is zero or the ray runs
// along the crossed boundary. A finished result sits in the output register while the next
// input beat is accepted.
`default_nettype none

module grid_raycast_column
    import grc_pkg::*;
#(
    parameter int MAP_DIM   = 64,
    parameter int MAX_STEPS = 100,
    parameter int TEX_SIZE  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [5:0]  i_cell_col,
    input  wire logic [5:0]  i_cell_row,
    input  wire logic [3:0]  i_cell_value,
    input  wire logic [9:0]  i_column,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [9:0]       o_out_column,
    output logic             o_hit,
    output logic             o_side,
    output logic [5:0]       o_hit_col,
    output logic [5:0]       o_hit_row,
    output logic [3:0]       o_wall_type,
    output logic [16:0]      o_perp_dist,
    output logic [11:0]      o_slice_height,
    output logic signed [11:0] o_slice_bottom,
    output logic [11:0]      o_slice_top,
    output logic [5:0]       o_tex_col
);

    t_cmd w_cmd;
    t_sts w_sts;

    grc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    grc_dp #(
        .MAP_DIM   (MAP_DIM),
        .MAX_STEPS (MAX_STEPS),
        .TEX_SIZE  (TEX_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cell_col     (i_cell_col),
        .i_cell_row     (i_cell_row),
        .i_cell_value   (i_cell_value),
        .i_column       (i_column),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_column   (o_out_column),
        .o_hit          (o_hit),
        .o_side         (o_side),
        .o_hit_col      (o_hit_col),
        .o_hit_row      (o_hit_row),
        .o_wall_type    (o_wall_type),
        .o_perp_dist    (o_perp_dist),
        .o_slice_height (o_slice_height),
        .o_slice_bottom (o_slice_bottom),
        .o_slice_top    (o_slice_top),
        .o_tex_col      (o_tex_col)
    );

endmodule

`default_nettype wire

// ===== rtl/grc_chk.sv =====
// Port-level checks of grid_raycast_column, attached by bind.
// Sees only the top-level ports; no package needed.
`default_nettype none

module grc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_opcode,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_hit,
    input wire logic [3:0]  o_wall_type,
    input wire logic [11:0] o_slice_height,
    input wire logic [11:0] o_slice_bottom,
    input wire logic [11:0] o_slice_top
);

    logic w_in_beat;
    assign w_in_beat = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slice_top)
            && $stable(o_wall_type))
        else $error("result changed while stalled");

    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_opcode |=> !o_in_ready)
        else $error("ready right after a cast beat");

    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && !i_opcode |=> o_in_ready)
        else $error("map write did not complete in one cycle");

    a_slice_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (12'(o_slice_top - o_slice_bottom) == {o_slice_height[11:1], 1'b0}))
        else $error("slice rows disagree with height");

    a_miss_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_wall_type == 4'd0)
        else $error("wall type on a miss");

endmodule

bind grid_raycast_column grc_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_opcode       (i_opcode),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_hit          (o_hit),
    .o_wall_type    (o_wall_type),
    .o_slice_height (o_slice_height),
    .o_slice_bottom (o_slice_bottom),
    .o_slice_top    (o_slice_top)
);

`default_nettype wire

// ===== sim/grid_raycast_column_tb.sv =====
// Testbench for grid_raycast_column: map writes and column casts with random idling and stalls.
// A scoreboard class predicts each cast from its own map, view and screen settings.
// Depends on grc_pkg and the grid_raycast_column RTL.
`default_nettype none

module grid_raycast_column_tb
    import grc_pkg::*;
();

    localparam int DIM = 64;
    localparam int STEP_LIMIT = 100;
    localparam int TEX = 64;
    localparam bit OP_WRITE = 1'b0;
    localparam bit OP_CAST = 1'b1;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [9:0]  column;
        logic        hit;
        logic        side;
        logic [5:0]  hit_col;
        logic [5:0]  hit_row;
        logic [3:0]  wall_type;
        logic [16:0] perp_dist;
        logic [11:0] slice_height;
        logic [11:0] slice_bottom;
        logic [11:0] slice_top;
        logic [5:0]  tex_col;
    } column_t;

    class column_scoreboard;
        logic [3:0]  cells [DIM*DIM];
        logic [15:0] view_px, view_py;
        logic signed [15:0] view_dx, view_dy, cam_x, cam_y;
        logic [10:0] scr_w, scr_h;
        column_t     pending[$];
        int          errors;

        function new();
            foreach (cells[i]) cells[i] = 0;
            view_px = 0; view_py = 0; view_dx = 16384; view_dy = 0;
            cam_x = 0; cam_y = 10638; scr_w = 640; scr_h = 480;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                CFG_POS_X:   view_px = v;
                CFG_POS_Y:   view_py = v;
                CFG_DIR_X:   view_dx = v;
                CFG_DIR_Y:   view_dy = v;
                CFG_PLANE_X: cam_x = v;
                CFG_PLANE_Y: cam_y = v;
                CFG_SCR_W:   scr_w = v[10:0];
                CFG_SCR_H:   scr_h = v[10:0];
                default: ;
            endcase
        endfunction

        static function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && ((n < 0) != (d < 0))) q -= 1;
            return q;
        endfunction

        function bit is_wall(longint gx, longint gy);
            if (gx < 0 || gy < 0 || gx >= DIM || gy >= DIM) return 1;
            return cells[gy*DIM + gx] != 0;
        endfunction

        function void note_beat(bit op, logic [5:0] c, logic [5:0] r, logic [3:0] v,
                                logic [9:0] col);
            longint w, h, k, rdx, rdy, ax, ay, px, py, gx, gy, sx, sy, nx, ny, pnum, d;
            longint den, other, base, perp, hgt, hitc, tx;
            bit wall, take_x;
            int side;
            column_t e;
            if (op == OP_WRITE) begin
                cells[r*DIM + c] = v;
                return;
            end
            w = scr_w ? scr_w : 1;
            h = scr_h;
            k = 2 * longint'(col) - w;
            rdx = view_dx + fdiv(longint'(cam_x) * k, w);
            rdy = view_dy + fdiv(longint'(cam_y) * k, w);
            ax = rdx < 0 ? -rdx : rdx;
            ay = rdy < 0 ? -rdy : rdy;
            px = view_px; py = view_py;
            gx = px >> 10; gy = py >> 10;
            sx = rdx < 0 ? -1 : 1; sy = rdy < 0 ? -1 : 1;
            nx = rdx < 0 ? (px & 1023) : 1024 - (px & 1023);
            ny = rdy < 0 ? (py & 1023) : 1024 - (py & 1023);
            pnum = 0; side = 1; wall = 0;
            for (int g = 0; g < 2 * (DIM + 64) + 8; g++) begin
                take_x = ax != 0 && (ay == 0 || nx * ay < ny * ax);
                if (take_x) begin
                    pnum = nx; nx += 1024; gx += sx; side = 0; d = gx * 1024 - px;
                end else begin
                    pnum = ny; ny += 1024; gy += sy; side = 1; d = gy * 1024 - py;
                end
                if (d < 0) d = -d;
                d = d >> 10;
                wall = is_wall(gx, gy);
                if (wall || d >= STEP_LIMIT) break;
            end
            den = side ? ay : ax;
            other = side ? rdx : rdy;
            base = side ? px : py;
            if (den == 0) begin
                perp = 131071; hgt = 0; hitc = base;
            end else begin
                perp = (pnum * 16384) / den;
                if (perp > 131071) perp = 131071;
                if (pnum == 0) hgt = 4095;
                else begin
                    hgt = (h * den) / (16 * pnum);
                    if (hgt > 4095) hgt = 4095;
                end
                hitc = base + fdiv(other * pnum, den);
            end
            tx = ((hitc & 1023) * TEX) >> 10;
            if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0)) tx = TEX - 1 - tx;
            e.column = col;
            e.hit = wall;
            e.side = side[0];
            e.hit_col = gx[5:0];
            e.hit_row = gy[5:0];
            e.wall_type = (gx >= 0 && gy >= 0 && gx < DIM && gy < DIM) ?
                          cells[gy*DIM + gx] : 4'd0;
            e.perp_dist = perp[16:0];
            e.slice_height = hgt[11:0];
            e.slice_bottom = 12'(h / 2 - hgt / 2);
            e.slice_top = 12'(h / 2 + hgt / 2);
            e.tex_col = tx[5:0];
            pending.push_back(e);
        endfunction

        function void check_beat(column_t a);
            column_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat for column %0d", a.column);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.column != e.column) begin
                $error("out_column exp %0d got %0d", e.column, a.column); errors++; end
            if (a.hit != e.hit) begin
                $error("hit exp %0d got %0d", e.hit, a.hit); errors++; end
            if (a.side != e.side) begin
                $error("side exp %0d got %0d", e.side, a.side); errors++; end
            if (a.hit_col != e.hit_col) begin
                $error("hit_col exp %0d got %0d", e.hit_col, a.hit_col); errors++; end
            if (a.hit_row != e.hit_row) begin
                $error("hit_row exp %0d got %0d", e.hit_row, a.hit_row); errors++; end
            if (a.wall_type != e.wall_type) begin
                $error("wall_type exp %0d got %0d", e.wall_type, a.wall_type); errors++; end
            if (a.perp_dist != e.perp_dist) begin
                $error("perp_dist exp %0d got %0d", e.perp_dist, a.perp_dist); errors++; end
            if (a.slice_height != e.slice_height) begin
                $error("slice_height exp %0d got %0d", e.slice_height, a.slice_height);
                errors++;
            end
            if (a.slice_bottom != e.slice_bottom) begin
                $error("slice_bottom exp %0d got %0d", $signed(e.slice_bottom),
                       $signed(a.slice_bottom));
                errors++;
            end
            if (a.slice_top != e.slice_top) begin
                $error("slice_top exp %0d got %0d", e.slice_top, a.slice_top); errors++; end
            if (a.tex_col != e.tex_col) begin
                $error("tex_col exp %0d got %0d", e.tex_col, a.tex_col); errors++; end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic i_in_valid, o_in_ready;
    logic i_opcode;
    logic [5:0] i_cell_col, i_cell_row;
    logic [3:0] i_cell_value;
    logic [9:0] i_column;
    logic o_out_valid, i_out_ready;
    logic [9:0] o_out_column;
    logic o_hit, o_side;
    logic [5:0] o_hit_col, o_hit_row;
    logic [3:0] o_wall_type;
    logic [16:0] o_perp_dist;
    logic [11:0] o_slice_height;
    logic signed [11:0] o_slice_bottom;
    logic [11:0] o_slice_top;
    logic [5:0] o_tex_col;

    grid_raycast_column dut (.*);

    column_scoreboard sb;
    int idle_cycles;
    bit calm, hold_off, sink_stop;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: sample at rising edge, drive ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_beat({o_out_column, o_hit, o_side, o_hit_col, o_hit_row, o_wall_type,
                           o_perp_dist, o_slice_height, o_slice_bottom, o_slice_top,
                           o_tex_col});
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (sink_stop) i_out_ready = 0;
            else if (hold_off) begin
                i_out_ready = 0;
                repeat (3000) @(negedge i_clk);
                hold_off = 0;
            end else
                i_out_ready = calm ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    initial begin
        @(posedge i_clk);
        wait (idle_cycles >= WATCHDOG);
        $display("Verification failed");
        $finish;
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.set_reg(idx, v);
    endtask

    task automatic send_beat(bit op, logic [5:0] c, logic [5:0] r, logic [3:0] v,
                             logic [9:0] col);
        if (!calm)
            while ($urandom_range(99) < 33) @(negedge i_clk);
        i_in_valid = 1; i_opcode = op; i_cell_col = c; i_cell_row = r;
        i_cell_value = v; i_column = col;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_beat(op, c, r, v, col);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic cast_rand(int wmax);
        send_beat(OP_CAST, 0, 0, 0, 10'($urandom_range(wmax)));
    endtask

    task automatic random_view();
        cfg_write(CFG_POS_X, 16'($urandom_range(0, 65535)));
        cfg_write(CFG_POS_Y, 16'($urandom_range(0, 65535)));
        cfg_write(CFG_DIR_X, 16'($urandom));
        cfg_write(CFG_DIR_Y, 16'($urandom));
        cfg_write(CFG_PLANE_X, 16'($urandom));
        cfg_write(CFG_PLANE_Y, 16'($urandom));
        cfg_write(CFG_SCR_W, 16'($urandom_range(0, 2047)));
        cfg_write(CFG_SCR_H, 16'($urandom_range(0, 2047)));
    endtask

    initial begin
        sb = new();
        calm = 0; hold_off = 0; sink_stop = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = CFG_POS_X; i_cfg_data = 0;
        i_in_valid = 0; i_opcode = OP_WRITE; i_cell_col = 0; i_cell_row = 0;
        i_cell_value = 0; i_column = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // directed: default view in empty map (outside walls, step limit), border walls
        cfg_write(CFG_POS_X, 16'd32 << 10 | 16'd512);
        cfg_write(CFG_POS_Y, 16'd32 << 10 | 16'd300);
        send_beat(OP_CAST, 0, 0, 0, 10'd0);
        send_beat(OP_CAST, 0, 0, 0, 10'd639);
        send_beat(OP_CAST, 0, 0, 0, 10'd1023);
        send_beat(OP_WRITE, 6'd40, 6'd32, 4'd15, 0);
        send_beat(OP_WRITE, 6'd63, 6'd63, 4'd1, 0);
        send_beat(OP_WRITE, 6'd0, 6'd0, 4'd9, 0);
        send_beat(OP_CAST, 0, 0, 0, 10'd320);
        send_beat(OP_CAST, 0, 0, 0, 10'd100);
        drain();
        // null ray, zero width, far corner position
        cfg_write(CFG_DIR_X, 16'd0);
        cfg_write(CFG_PLANE_Y, 16'd0);
        cfg_write(CFG_SCR_W, 16'd0);
        cfg_write(CFG_SCR_H, 16'd2047);
        send_beat(OP_CAST, 0, 0, 0, 10'd0);
        send_beat(OP_CAST, 0, 0, 0, 10'd1);
        drain();
        cfg_write(CFG_POS_X, 16'hFFFF);
        cfg_write(CFG_POS_Y, 16'hFFFF);
        cfg_write(CFG_DIR_X, 16'h8000);
        cfg_write(CFG_DIR_Y, 16'h7FFF);
        cfg_write(CFG_PLANE_X, 16'h7FFF);
        cfg_write(CFG_PLANE_Y, 16'h8000);
        cfg_write(CFG_SCR_W, 16'd1024);
        cfg_write(CFG_SCR_H, 16'd1);
        send_beat(OP_CAST, 0, 0, 0, 10'd512);
        send_beat(OP_CAST, 0, 0, 0, 10'd0);
        drain();
        // wall adjacent to an on-boundary viewer gives zero distance
        cfg_write(CFG_POS_X, 16'd10 << 10);
        cfg_write(CFG_POS_Y, 16'd10 << 10);
        cfg_write(CFG_DIR_X, 16'h8000);
        cfg_write(CFG_DIR_Y, 16'd0);
        cfg_write(CFG_PLANE_X, 16'd0);
        cfg_write(CFG_PLANE_Y, 16'd0);
        send_beat(OP_WRITE, 6'd9, 6'd10, 4'd3, 0);
        send_beat(OP_CAST, 0, 0, 0, 10'd3);
        drain();

        // random phases: rooms with walls, then casts; one long receiver hold-off
        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph == 5);
            random_view();
            if (ph % 3 == 0) begin
                cfg_write(CFG_SCR_W, 16'($urandom_range(1, 64)));
                cfg_write(CFG_SCR_H, 16'($urandom_range(1, 1024)));
            end
            for (int n = 0; n < 40; n++)
                send_beat(OP_WRITE, 6'($urandom), 6'($urandom),
                          ($urandom_range(99) < 50) ? 4'd0 : 4'($urandom), 0);
            if (ph == 3) hold_off = 1;
            for (int n = 0; n < 80; n++) begin
                if ($urandom_range(99) < 15)
                    send_beat(OP_WRITE, 6'($urandom), 6'($urandom), 4'($urandom), 0);
                else
                    cast_rand(($urandom_range(99) < 80) ? (sb.scr_w ? sb.scr_w - 1 : 0)
                                                       : 1023);
            end
            drain();
        end

        calm = 0;
        drain();
        sink_stop = 1;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
